// ===== rtl/ibbs_pkg.sv =====
// shared types and constants for the ir beam-break sequencer
package ibbs_pkg;

    // tick count limits of the relay sequence
    localparam logic [7:0] RX0_TIMEOUT  = 8'd85;
    localparam logic [7:0] PRE_PULSE    = 8'd24;
    localparam logic [7:0] PULSE_LEN    = 8'd20;
    localparam logic [7:0] SETTLE_LEN   = 8'd64;
    localparam logic [7:0] RX_TIMEOUT   = 8'd130;
    localparam logic [7:0] REARM_LEN    = 8'd18;

    // failure counter saturation and reset value
    localparam logic [6:0] FAIL_SAT     = 7'd100;

    // configuration register indexes and reset values
    localparam int         CFG_IDX_W        = 1;
    localparam int         CFG_DATA_W       = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_BROKEN_THRESHOLD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLDOFF_RELOAD   = 1'd1;
    localparam logic [5:0] THRESHOLD_RST    = 6'd3;
    localparam logic [7:0] HOLDOFF_RST      = 8'd20;

    // one evaluation pass
    typedef struct packed {
        logic rx2_n;
        logic rx1_n;
        logic rx0_n;
        logic slow_strobe;
        logic tick;
    } item_t;

    // one result of a pass
    typedef struct packed {
        logic [3:0] seq_state;
        logic       broken_event;
        logic       emit1_on;
        logic       emit0_on;
    } result_t;

endpackage

// ===== rtl/ir_beam_break_sequencer.sv =====
// top level of the ir beam-break relay sequencer
//
// Each slave beat is one evaluation pass: tick, 50 ms strobe and the three
// active-low receiver levels. Each pass gives exactly one master beat with
// the emitter enables, the broken-beam pulse and the sequence state after
// the pass.
// The pass goes through an input register, the sequence logic and a
// result register; a beat reaches the master side from the result register.
// One beat per cycle is sustained while the master side takes beats: the
// sequence state and counters update as a pass moves from the input
// register to the result register.
// When the receiver stalls, the result register holds its beat and the
// input register still takes one more beat; s_tready then drops until the
// master side moves again. No beat is lost or repeated.
// Configuration writes (broken threshold, holdoff reload) take effect at
// once and are to be made by the user while the block is idle; the block does not enforce it.
// Synchronous reset clears both registers, restarts the sequence at state 0
// with the failure count at 100, holdoff 0, emitters off, and loads the
// register defaults of 3 and 20.
module ir_beam_break_sequencer (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration write port
    input  logic                            cfg_we,
    input  logic [ibbs_pkg::CFG_IDX_W-1:0]  cfg_idx,
    input  logic [ibbs_pkg::CFG_DATA_W-1:0] cfg_wdata,
    // slave side
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,  // tick, slow_strobe, rx0_n, rx1_n, rx2_n, 0
    // master side
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [7:0]                      m_tdata   // emit0_on, emit1_on, broken_event,
                                                      // seq_state[3:0], 0
);
    import ibbs_pkg::*;

    item_t   s_item;
    item_t   item;
    logic    item_valid;
    logic    advance;
    logic    fire;
    result_t result;
    result_t m_result;

    assign s_item = s_tdata[4:0];
    assign fire   = item_valid && advance;
    assign m_tdata = {1'b0, m_result};

    // input register
    ibbs_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_item     (s_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    // sequencer
    ibbs_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_wdata (cfg_wdata),
        .fire      (fire),
        .item      (item),
        .result    (result)
    );

    // result register
    ibbs_out_reg u_out_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (item_valid),
        .result   (result),
        .advance  (advance),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_result (m_result)
    );

endmodule

// ===== rtl/ibbs_in_reg.sv =====
// input register stage holding one evaluation pass
module ibbs_in_reg (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  ibbs_pkg::item_t s_item,
    input  logic           advance,
    output logic           item_valid,
    output ibbs_pkg::item_t item
);
    import ibbs_pkg::*;

    logic  valid_reg;
    item_t item_reg;

    // free slot, or the held beat moves on this cycle
    assign s_tready   = !valid_reg || advance;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    // valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            valid_reg <= 1'b1;
        end else if (advance) begin
            valid_reg <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg <= s_item;
        end
    end

endmodule

// ===== rtl/ibbs_core.sv =====
// relay sequence, failure counting and holdoff for one pass
module ibbs_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [ibbs_pkg::CFG_IDX_W-1:0]    cfg_idx,
    input  logic [ibbs_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                              fire,
    input  ibbs_pkg::item_t                   item,
    output ibbs_pkg::result_t                 result
);
    import ibbs_pkg::*;

    typedef enum logic [3:0] {
        ST_WAIT_RX0   = 4'd0,
        ST_RX0_END    = 4'd1,
        ST_PRE_PULSE0 = 4'd2,
        ST_PULSE0     = 4'd3,
        ST_SETTLE0    = 4'd4,
        ST_WAIT_RX1   = 4'd5,
        ST_RX1_END    = 4'd6,
        ST_PRE_PULSE1 = 4'd7,
        ST_PULSE1     = 4'd8,
        ST_SETTLE1    = 4'd9,
        ST_WAIT_RX2   = 4'd10,
        ST_RX2_END    = 4'd11,
        ST_REARM      = 4'd12,
        ST_ERROR      = 4'd13
    } state_t;

    state_t     state_reg, state_next;
    logic [7:0] tick_count_reg, tick_count_next;
    logic [6:0] fail_count_reg, fail_count_next;
    logic [7:0] holdoff_reg, holdoff_next;
    logic       emit0_reg, emit0_next;
    logic       emit1_reg, emit1_next;
    logic [5:0] threshold_reg;
    logic [7:0] reload_reg;

    logic [7:0] tc;
    logic [6:0] fail_mid;
    logic       event_hit;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg <= THRESHOLD_RST;
            reload_reg    <= HOLDOFF_RST;
        end else if (cfg_we) begin
            case (cfg_idx)
                CFG_BROKEN_THRESHOLD: threshold_reg <= cfg_wdata[5:0];
                CFG_HOLDOFF_RELOAD:   reload_reg    <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    // sequence step
    always_comb begin
        tc              = item.tick ? tick_count_reg + 8'd1 : tick_count_reg;
        state_next      = state_reg;
        tick_count_next = tc;
        fail_mid        = fail_count_reg;
        emit0_next      = emit0_reg;
        emit1_next      = emit1_reg;
        case (state_reg)
            ST_WAIT_RX0: begin
                if (!item.rx0_n) state_next = ST_RX0_END;
                if (tc >= RX0_TIMEOUT) state_next = ST_ERROR;
            end
            ST_RX0_END: begin
                if (item.rx0_n) begin
                    state_next      = ST_PRE_PULSE0;
                    tick_count_next = 8'd0;
                end
            end
            ST_PRE_PULSE0: begin
                if (tc >= PRE_PULSE) begin
                    state_next      = ST_PULSE0;
                    emit0_next      = 1'b1;
                    tick_count_next = 8'd0;
                end
            end
            ST_PULSE0: begin
                // count runs on into the settle wait
                if (tc >= PULSE_LEN) begin
                    state_next = ST_SETTLE0;
                    emit0_next = 1'b0;
                end
            end
            ST_SETTLE0: begin
                if (tc >= SETTLE_LEN) state_next = ST_WAIT_RX1;
            end
            ST_WAIT_RX1: begin
                if (!item.rx1_n) state_next = ST_RX1_END;
                if (tc >= RX_TIMEOUT) state_next = ST_ERROR;
            end
            ST_RX1_END: begin
                if (item.rx1_n) begin
                    state_next      = ST_PRE_PULSE1;
                    tick_count_next = 8'd0;
                end
            end
            ST_PRE_PULSE1: begin
                if (tc >= PRE_PULSE) begin
                    state_next      = ST_PULSE1;
                    emit1_next      = 1'b1;
                    tick_count_next = 8'd0;
                end
            end
            ST_PULSE1: begin
                if (tc >= PULSE_LEN) begin
                    state_next      = ST_SETTLE1;
                    emit1_next      = 1'b0;
                    tick_count_next = 8'd0;
                end
            end
            ST_SETTLE1: begin
                if (tc >= SETTLE_LEN) state_next = ST_WAIT_RX2;
            end
            ST_WAIT_RX2: begin
                // beam seen clears the failure run even if the timeout wins
                if (!item.rx2_n) begin
                    state_next = ST_RX2_END;
                    fail_mid   = 7'd0;
                end
                if (tc >= RX_TIMEOUT) state_next = ST_ERROR;
            end
            ST_RX2_END: begin
                if (item.rx2_n) begin
                    state_next      = ST_REARM;
                    tick_count_next = 8'd0;
                end
            end
            ST_REARM: begin
                if (tc >= REARM_LEN) state_next = ST_WAIT_RX0;
            end
            ST_ERROR: begin
                if (fail_count_reg < FAIL_SAT) fail_mid = fail_count_reg + 7'd1;
                tick_count_next = 8'd0;
                state_next      = ST_WAIT_RX0;
            end
            default: begin
                state_next = ST_WAIT_RX0;
            end
        endcase

        // broken check, then holdoff countdown
        event_hit       = (fail_mid == {1'b0, threshold_reg}) && (holdoff_reg == 8'd0);
        fail_count_next = event_hit ? fail_mid + 7'd1 : fail_mid;
        holdoff_next    = event_hit ? reload_reg : holdoff_reg;
        if (item.slow_strobe && holdoff_next != 8'd0) holdoff_next = holdoff_next - 8'd1;
    end

    assign result.emit0_on     = emit0_next;
    assign result.emit1_on     = emit1_next;
    assign result.broken_event = event_hit;
    assign result.seq_state    = state_next;

    // state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_WAIT_RX0;
            tick_count_reg <= 8'd0;
            fail_count_reg <= FAIL_SAT;
            holdoff_reg    <= 8'd0;
            emit0_reg      <= 1'b0;
            emit1_reg      <= 1'b0;
        end else if (fire) begin
            state_reg      <= state_next;
            tick_count_reg <= tick_count_next;
            fail_count_reg <= fail_count_next;
            holdoff_reg    <= holdoff_next;
            emit0_reg      <= emit0_next;
            emit1_reg      <= emit1_next;
        end
    end

endmodule

// ===== rtl/ibbs_out_reg.sv =====
// result register toward the master side
module ibbs_out_reg (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load,
    input  ibbs_pkg::result_t result,
    output logic              advance,
    output logic              m_tvalid,
    input  logic              m_tready,
    output ibbs_pkg::result_t m_result
);
    import ibbs_pkg::*;

    logic    valid_reg;
    result_t result_reg;

    // register free, or its beat leaves this cycle
    assign advance  = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_result = result_reg;

    // valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= load;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (advance && load) begin
            result_reg <= result;
        end
    end

endmodule
